// ===== rtl/analog_trigger_normalizer_macros.svh =====
// Assertion macros shared by the trigger normalizer RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ANALOG_TRIGGER_NORMALIZER_MACROS_SVH
`define ANALOG_TRIGGER_NORMALIZER_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge.
`define ATN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled at the rising clock edge.
`define ATN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/atn_pkg.sv =====
// Shared types and constants for the analog trigger normalizer.
// No dependencies; compiled before the interfaces and modules.
package atn_pkg;

    localparam int LEVEL_BITS     = 16;
    localparam int CAL_HIGH_RESET = 4095;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SOURCE = 2'd1,
        ST_NO_ADC    = 2'd2,
        ST_BAD_CAL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_CAL_LOW     = 2'd0,
        REG_CAL_HIGH    = 2'd1,
        REG_DEAD_BAND   = 2'd2,
        REG_INVERT_AXIS = 2'd3
    } reg_idx_t;

    // Control that travels alongside the data in each pipeline stage.
    typedef struct packed {
        logic    valid;
        status_t status;
    } pipe_ctl_t;

endpackage

// ===== rtl/atn_in_if.sv =====
// Sample channel interface: valid/ready handshake with the raw ADC payload.
// Depends on nothing; the sample width follows SAMPLE_BITS.
interface atn_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   source_present;
    logic                   converter_ready;

    modport source (
        output valid, sample_value, source_present, converter_ready,
        input  ready
    );

    modport sink (
        input  valid, sample_value, source_present, converter_ready,
        output ready
    );
endinterface

// ===== rtl/atn_out_if.sv =====
// Result channel interface: valid/ready handshake with level and status.
// Depends on atn_pkg for the level width and status type.
interface atn_out_if;
    logic                              valid;
    logic                              ready;
    logic [atn_pkg::LEVEL_BITS-1:0]    level;
    atn_pkg::status_t                  status;

    modport source (
        output valid, level, status,
        input  ready
    );

    modport sink (
        input  valid, level, status,
        output ready
    );
endinterface

// ===== rtl/atn_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on atn_pkg; the caller guarantees the quotient fits in LEVEL_BITS.
module atn_div #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         adv,
    input  atn_pkg::pipe_ctl_t                           in_ctl,
    input  logic [SAMPLE_BITS+atn_pkg::LEVEL_BITS-1:0]   num,
    input  logic [SAMPLE_BITS-1:0]                       divisor,
    output atn_pkg::pipe_ctl_t                           out_ctl,
    output logic [atn_pkg::LEVEL_BITS-1:0]               quotient
);
    import atn_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int STEPS = LEVEL_BITS;

    pipe_ctl_t             ctl_reg [STEPS];
    logic [SB-1:0]         rem_reg [STEPS];
    logic [LEVEL_BITS-1:0] low_reg [STEPS];
    logic [LEVEL_BITS-1:0] quo_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        pipe_ctl_t             ctl_prev;
        logic [SB-1:0]         rem_prev;
        logic [LEVEL_BITS-1:0] low_prev;
        logic [LEVEL_BITS-1:0] quo_prev;
        logic [SB:0]           trial;
        logic [SB:0]           diff;
        logic                  fits;

        if (i == 0) begin : g_first
            // The upper bits of the dividend are already below the divisor.
            assign ctl_prev = in_ctl;
            assign rem_prev = num[SB+LEVEL_BITS-1:LEVEL_BITS];
            assign low_prev = num[LEVEL_BITS-1:0];
            assign quo_prev = '0;
        end
        else begin : g_next
            assign ctl_prev = ctl_reg[i-1];
            assign rem_prev = rem_reg[i-1];
            assign low_prev = low_reg[i-1];
            assign quo_prev = quo_reg[i-1];
        end

        assign trial = {rem_prev, low_prev[LEVEL_BITS-1]};
        assign diff  = trial - {1'b0, divisor};
        assign fits  = (trial >= {1'b0, divisor});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i] <= '{valid: 1'b0, status: ST_OK};
            end
            else if (adv)
            begin
                ctl_reg[i] <= ctl_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i] <= fits ? diff[SB-1:0] : trial[SB-1:0];
                low_reg[i] <= {low_prev[LEVEL_BITS-2:0], 1'b0};
                quo_reg[i] <= {quo_prev[LEVEL_BITS-2:0], fits};
            end
        end
    end

    assign out_ctl  = ctl_reg[STEPS-1];
    assign quotient = quo_reg[STEPS-1];

endmodule

// ===== rtl/analog_trigger_normalizer.sv =====
// Each sample passes 3 front stages, 16 divider stages and an output register before its
// result is valid. Throughput: one sample per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and loads the default calibration (full range,
// no dead band, no inversion). Depends on atn_pkg, atn_in_if, atn_out_if, atn_div and the macros header.
module analog_trigger_normalizer #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_idx,
    input  logic [SAMPLE_BITS-1:0] cfg_data,
    atn_in_if.sink                 in_ch,
    atn_out_if.source              out_ch
);
    import atn_pkg::*;

    `include "analog_trigger_normalizer_macros.svh"

    localparam int SB = SAMPLE_BITS;
    localparam int NW = SB + LEVEL_BITS;

    // Calibration registers.
    logic [SB-1:0] cal_low_reg;
    logic [SB-1:0] cal_high_reg;
    logic [SB-1:0] dead_band_reg;
    logic          invert_axis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_low_reg     <= '0;
            cal_high_reg    <= SB'(CAL_HIGH_RESET);
            dead_band_reg   <= '0;
            invert_axis_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_CAL_LOW:     cal_low_reg     <= cfg_data;
                REG_CAL_HIGH:    cal_high_reg    <= cfg_data;
                REG_DEAD_BAND:   dead_band_reg   <= cfg_data;
                REG_INVERT_AXIS: invert_axis_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Derived from the calibration; the user must change it only while the pipe is empty (unenforced).
    logic [SB-1:0] span;
    logic [SB-1:0] active;
    logic          cal_bad;

    assign span    = cal_high_reg - cal_low_reg;
    assign active  = span - dead_band_reg;
    assign cal_bad = (cal_low_reg >= cal_high_reg) || (dead_band_reg >= span);

    // Every stage moves together; the output register decides.
    logic          out_valid_reg;
    logic          adv;

    assign adv         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // Stage 1: status and clamp.
    pipe_ctl_t     s1_ctl_reg;
    logic [SB-1:0] s1_clamp_reg;
    pipe_ctl_t     s1_ctl_next;
    logic [SB-1:0] s1_clamp_next;

    always_comb
    begin
        s1_ctl_next.valid = in_ch.valid;
        if (!in_ch.source_present)
        begin
            s1_ctl_next.status = ST_NO_SOURCE;
        end
        else if (!in_ch.converter_ready)
        begin
            s1_ctl_next.status = ST_NO_ADC;
        end
        else if (cal_bad)
        begin
            s1_ctl_next.status = ST_BAD_CAL;
        end
        else
        begin
            s1_ctl_next.status = ST_OK;
        end

        if (in_ch.sample_value < cal_low_reg)
        begin
            s1_clamp_next = cal_low_reg;
        end
        else if (in_ch.sample_value > cal_high_reg)
        begin
            s1_clamp_next = cal_high_reg;
        end
        else
        begin
            s1_clamp_next = in_ch.sample_value;
        end
    end

    // Stage 2: position past the dead band.
    pipe_ctl_t     s2_ctl_reg;
    logic [SB-1:0] s2_gap_reg;
    logic [SB-1:0] pos;
    logic [SB-1:0] s2_gap_next;

    always_comb
    begin
        pos = invert_axis_reg ? (cal_high_reg - s1_clamp_reg) : (s1_clamp_reg - cal_low_reg);
        // Inside the dead band the gap is zero, and the rounded quotient then is zero too.
        s2_gap_next = (pos > dead_band_reg) ? (pos - dead_band_reg) : '0;
    end

    // Stage 3: dividend gap * 65535 + active / 2.
    pipe_ctl_t     s3_ctl_reg;
    logic [NW-1:0] s3_num_reg;
    logic [NW-1:0] s3_num_next;

    assign s3_num_next = {s2_gap_reg, {LEVEL_BITS{1'b0}}} - NW'(s2_gap_reg)
                         + NW'(active >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '{valid: 1'b0, status: ST_OK};
            s2_ctl_reg <= '{valid: 1'b0, status: ST_OK};
            s3_ctl_reg <= '{valid: 1'b0, status: ST_OK};
        end
        else if (adv)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_clamp_reg <= s1_clamp_next;
            s2_gap_reg   <= s2_gap_next;
            s3_num_reg   <= s3_num_next;
        end
    end

    // Stages 4 to 19: one quotient bit per stage.
    pipe_ctl_t             div_ctl;
    logic [LEVEL_BITS-1:0] div_quo;

    atn_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_ctl   (s3_ctl_reg),
        .num      (s3_num_reg),
        .divisor  (active),
        .out_ctl  (div_ctl),
        .quotient (div_quo)
    );

    // Output register.
    logic [LEVEL_BITS-1:0] out_level_reg;
    status_t               out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_level_reg  <= (div_ctl.status == ST_OK) ? div_quo : '0;
            out_status_reg <= div_ctl.status;
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.level  = out_level_reg;
    assign out_ch.status = out_status_reg;

    // Any error status must come with a zero level.
    `ATN_ASSERT_NOW(a_err_zero_level, out_valid_reg && (out_status_reg != ST_OK), out_level_reg == '0)
    // An item reaching the position stage as good must see a valid calibration.
    `ATN_ASSERT_NOW(a_ok_needs_cal, s1_ctl_reg.valid && (s1_ctl_reg.status == ST_OK), !cal_bad)
    // A sample transfer always lands in the first stage.
    `ATN_ASSERT_NEXT(a_accept_loads, in_ch.valid && in_ch.ready, s1_ctl_reg.valid)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for analog_trigger_normalizer: sample and result channels
// with random idling, calibration phases, and a scoreboard that predicts level/status.
// Depends on atn_pkg, atn_in_if, atn_out_if and the normalizer RTL.
`timescale 1ns / 100ps

module testbench;
    import atn_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam bit [SAMPLE_BITS-1:0] MAX_RAW = '1;
    localparam int FULL_SCALE  = 65535;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 30;
    localparam int HOLD_CYCLES = 240;

    // Keeps its own copy of the calibration and a queue of expected results.
    class trigger_scoreboard;
        bit [SAMPLE_BITS-1:0] cal_low;
        bit [SAMPLE_BITS-1:0] cal_high;
        bit [SAMPLE_BITS-1:0] dead_band;
        bit                   invert_axis;
        bit [LEVEL_BITS-1:0]  level_q[$];
        status_t              status_q[$];
        int unsigned          mismatches;

        function new();
            cal_low     = '0;
            cal_high    = SAMPLE_BITS'(CAL_HIGH_RESET);
            dead_band   = '0;
            invert_axis = 1'b0;
            mismatches  = 0;
        endfunction

        function void set_reg(reg_idx_t idx, bit [SAMPLE_BITS-1:0] data);
            case (idx)
                REG_CAL_LOW:     cal_low = data;
                REG_CAL_HIGH:    cal_high = data;
                REG_DEAD_BAND:   dead_band = data;
                REG_INVERT_AXIS: invert_axis = data[0];
                default:         ;
            endcase
        endfunction

        function void note_sample(bit [SAMPLE_BITS-1:0] raw, bit src, bit rdy);
            status_t              st;
            bit [LEVEL_BITS-1:0]  lvl;
            bit [SAMPLE_BITS-1:0] clamped;
            bit [SAMPLE_BITS-1:0] pos;
            bit [SAMPLE_BITS-1:0] active;
            longint unsigned      num;
            longint unsigned      quo;
            st  = ST_OK;
            lvl = '0;
            if (!src)
                st = ST_NO_SOURCE;
            else if (!rdy)
                st = ST_NO_ADC;
            else if (cal_low >= cal_high || dead_band >= cal_high - cal_low)
                st = ST_BAD_CAL;
            else
            begin
                clamped = raw;
                if (clamped < cal_low)
                    clamped = cal_low;
                else if (clamped > cal_high)
                    clamped = cal_high;
                pos = invert_axis ? cal_high - clamped : clamped - cal_low;
                if (pos > dead_band)
                begin
                    active = cal_high - cal_low - dead_band;
                    num = longint'(pos - dead_band) * FULL_SCALE + longint'(active / 2);
                    quo = num / active;
                    lvl = (quo > FULL_SCALE) ? LEVEL_BITS'(FULL_SCALE) : quo[LEVEL_BITS-1:0];
                end
            end
            level_q.push_back(lvl);
            status_q.push_back(st);
        endfunction

        function void check_result(bit [LEVEL_BITS-1:0] lvl, status_t st);
            bit [LEVEL_BITS-1:0] exp_lvl;
            status_t             exp_st;
            if (level_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: result with nothing expected: level %0d status %s",
                             $realtime, lvl, st.name());
                mismatches++;
                return;
            end
            exp_lvl = level_q.pop_front();
            exp_st  = status_q.pop_front();
            if (lvl !== exp_lvl || st !== exp_st)
            begin
                if (mismatches < 10)
                    $display("%0t: mismatch: expected level %0d status %s, got %0d %s",
                             $realtime, exp_lvl, exp_st.name(), lvl, st.name());
                mismatches++;
            end
        endfunction

        function int pending();
            return level_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [1:0]             cfg_idx;
    logic [SAMPLE_BITS-1:0] cfg_data;

    atn_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    atn_out_if out_ch ();

    analog_trigger_normalizer #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    trigger_scoreboard sb = new();
    bit                source_eager;
    bit                sink_eager;
    bit                hold_request;
    int unsigned       cycle_count;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: a random stall after each transfer unless sink_eager is set, plus one long hold-off on request.
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        bit hold_taken;
        stall_left = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                sb.check_result(out_ch.level, out_ch.status);
                stall_left = sink_eager ? 0 : $urandom_range(0, 9);
            end
            if (hold_request && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send_sample(input bit [SAMPLE_BITS-1:0] raw, input bit src, input bit rdy);
        int gap;
        gap = source_eager ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.sample_value    <= raw;
        in_ch.source_present  <= src;
        in_ch.converter_ready <= rdy;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        sb.note_sample(raw, src, rdy);
    endtask

    // Called in the step of the last transfer; drains the pipeline before any write.
    task automatic finish_phase();
        in_ch.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input bit [SAMPLE_BITS-1:0] lo, input bit [SAMPLE_BITS-1:0] hi,
                                input bit [SAMPLE_BITS-1:0] db,
                                input bit [SAMPLE_BITS-1:0] inv_word);
        reg_idx_t             idx;
        bit [SAMPLE_BITS-1:0] data;
        for (int i = 0; i < 4; i++)
        begin
            idx = reg_idx_t'(i);
            case (idx)
                REG_CAL_LOW:   data = lo;
                REG_CAL_HIGH:  data = hi;
                REG_DEAD_BAND: data = db;
                default:       data = inv_word;
            endcase
            cfg_we   <= 1'b1;
            cfg_idx  <= idx;
            cfg_data <= data;
            @(posedge clk);
            sb.set_reg(idx, data);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        int lo;
        int hi;
        int db;
        if ($urandom_range(0, 9) < 8)
        begin
            lo = $urandom_range(0, MAX_RAW - 1);
            hi = $urandom_range(lo + 1, MAX_RAW);
            db = $urandom_range(0, 1) ? 0 : $urandom_range(0, hi - lo - 1);
        end
        else
        begin
            lo = $urandom_range(0, MAX_RAW);
            hi = $urandom_range(0, MAX_RAW);
            db = $urandom_range(0, MAX_RAW);
        end
        apply_config(SAMPLE_BITS'(lo), SAMPLE_BITS'(hi), SAMPLE_BITS'(db),
                     SAMPLE_BITS'($urandom));
    endtask

    // Readings cluster around the calibration edges and the dead band boundary.
    function automatic bit [SAMPLE_BITS-1:0] pick_sample();
        int v;
        int base;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(0, MAX_RAW);
            5:             v = $urandom_range(0, 1) ? 0 : MAX_RAW;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       base = int'(sb.cal_low);
                    1:       base = int'(sb.cal_high);
                    2:       base = int'(sb.cal_low) + int'(sb.dead_band);
                    default: base = int'(sb.cal_high) - int'(sb.dead_band);
                endcase
                v = base + int'($urandom_range(0, 4)) - 2;
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > MAX_RAW)
            v = MAX_RAW;
        return SAMPLE_BITS'(v);
    endfunction

    initial
    begin
        hold_request          = 1'b0;
        source_eager          = 1'b0;
        sink_eager            = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = REG_CAL_LOW;
        cfg_data              = '0;
        in_ch.valid           = 1'b0;
        in_ch.sample_value    = '0;
        in_ch.source_present  = 1'b0;
        in_ch.converter_ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default calibration: full range, then the availability checks and their order.
        send_sample(0, 1'b1, 1'b1);
        send_sample(MAX_RAW, 1'b1, 1'b1);
        send_sample(2048, 1'b1, 1'b1);
        send_sample(MAX_RAW, 1'b0, 1'b1);
        send_sample(MAX_RAW, 1'b1, 1'b0);
        send_sample(0, 1'b0, 1'b0);
        finish_phase();

        // Clamping on both sides and the dead band edge.
        apply_config(100, 3000, 50, 0);
        send_sample(0, 1'b1, 1'b1);
        send_sample(MAX_RAW, 1'b1, 1'b1);
        send_sample(150, 1'b1, 1'b1);
        send_sample(151, 1'b1, 1'b1);
        send_sample(3000, 1'b1, 1'b1);
        finish_phase();

        apply_config(100, 3000, 50, 12'hFFF);
        send_sample(0, 1'b1, 1'b1);
        send_sample(3000, 1'b1, 1'b1);
        send_sample(2950, 1'b1, 1'b1);
        finish_phase();

        // Invalid calibrations; a missing converter still outranks them.
        apply_config(2000, 2000, 0, 0);
        send_sample(2000, 1'b1, 1'b1);
        send_sample(2000, 1'b1, 1'b0);
        finish_phase();
        apply_config(3000, 100, 0, 0);
        send_sample(1000, 1'b1, 1'b1);
        finish_phase();
        apply_config(100, 3000, 2900, 0);
        send_sample(3000, 1'b1, 1'b1);
        finish_phase();

        // Active span of one count, and a span of one count.
        apply_config(100, 3000, 2899, 0);
        send_sample(3000, 1'b1, 1'b1);
        send_sample(2999, 1'b1, 1'b1);
        finish_phase();
        apply_config(MAX_RAW - 1'b1, MAX_RAW, 0, 12'hFFE);
        send_sample(MAX_RAW, 1'b1, 1'b1);
        send_sample(0, 1'b1, 1'b1);
        finish_phase();

        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase == 0)
                apply_config(0, MAX_RAW, 0, 1);
            else
                random_config();
            source_eager = ($urandom_range(0, 3) == 0);
            sink_eager   = ($urandom_range(0, 3) == 0);
            if (phase == 3)
            begin
                source_eager = 1'b1;
                hold_request = 1'b1;
            end
            for (int n = 0; n < 80; n++)
                send_sample(pick_sample(), $urandom_range(0, 15) != 0,
                            $urandom_range(0, 15) != 0);
            finish_phase();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/atn_pkg.sv
rtl/atn_in_if.sv
rtl/atn_out_if.sv
rtl/atn_div.sv
rtl/analog_trigger_normalizer.sv
sim/testbench.sv
